// ===== hdl/bpfa_pkg.sv =====
package bpfa_pkg;

    // Capacity of the map in page frames (a multiple of the word width).
    localparam int NUM_PAGES = 65536;
    localparam int WORD_W    = 64;
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int MAP_WORDS = NUM_PAGES / WORD_W;
    localparam int WORD_AW   = $clog2(MAP_WORDS);
    localparam int PTR_W     = WORD_AW + 1;

    localparam int PAGE_W    = 16;
    localparam int COUNT_W   = 17;
    localparam int STATUS_W  = 2;

    // Reset value of page_count, clipped to the capacity.
    localparam int CNT_RST   = 65536;
    localparam int LIM_RST   = (CNT_RST > NUM_PAGES) ? NUM_PAGES : CNT_RST;
    localparam int NW_RST    = (LIM_RST + WORD_W - 1) / WORD_W;
    localparam int TW_RST    = LIM_RST / WORD_W;
    localparam int TAIL_RST  = LIM_RST % WORD_W;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_OOM     = 2'd1,
        ST_ALREADY = 2'd2,
        ST_RANGE   = 2'd3
    } t_status;

    // Controller -> datapath
    typedef struct packed {
        logic accept;    // latch request, issue read of its word
        logic clr;       // write one zero word of the clearing pass
        logic scan;      // scan step of an allocate
        logic free_chk;  // test the bit of a free
        logic wr;        // write back the modified word, adjust count
        logic out_load;  // move staged result into the output register
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic clr_done;
        logic req_alloc;
        logic range_err;
        logic hit;
        logic miss;
        logic already;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== hdl/bpfa_req_if.sv =====
interface bpfa_req_if;
    import bpfa_pkg::*;

    logic              valid;
    logic              ready;
    logic              op;
    logic [PAGE_W-1:0] page_index;

    modport source (output valid, output op, output page_index, input ready);
    modport sink   (input valid, input op, input page_index, output ready);
endinterface

// ===== hdl/bpfa_rsp_if.sv =====
interface bpfa_rsp_if;
    import bpfa_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   alloc_index;
    logic [COUNT_W-1:0]  free_count;

    modport source (output valid, output status, output alloc_index, output free_count,
                    input ready);
    modport sink   (input valid, input status, input alloc_index, input free_count,
                    output ready);
endinterface

// ===== hdl/bpfa_cfg_if.sv =====
interface bpfa_cfg_if;
    import bpfa_pkg::*;

    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] page_count;

    modport source (output valid, output page_count, input ready);
    modport sink   (input valid, input page_count, output ready);
endinterface

// ===== hdl/bpfa_ctrl.sv =====
module bpfa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  bpfa_pkg::t_dp_sts i_sts,
    output bpfa_pkg::t_dp_cmd o_cmd
);
    import bpfa_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR    = 7'b0000001,
        S_IDLE     = 7'b0000010,
        S_SCAN     = 7'b0000100,
        S_FREE_CHK = 7'b0001000,
        S_WRITE    = 7'b0010000,
        S_DONE     = 7'b0100000,
        S_SPARE    = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.req_alloc) begin
                        n_state = S_SCAN;
                    end else if (i_sts.range_err) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_FREE_CHK;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.hit) begin
                    n_state = S_WRITE;
                end else if (i_sts.miss) begin
                    n_state = S_DONE;
                end
            end
            S_FREE_CHK: begin
                o_cmd.free_chk = 1'b1;
                n_state = i_sts.already ? S_DONE : S_WRITE;
            end
            S_WRITE: begin
                o_cmd.wr = 1'b1;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_req_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hdl/bpfa_dpath.sv =====
module bpfa_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bpfa_pkg::t_dp_cmd              i_cmd,
    output bpfa_pkg::t_dp_sts              o_sts,
    input  logic                           i_req_op,
    input  logic [bpfa_pkg::PAGE_W-1:0]    i_req_idx,
    input  logic                           i_cfg_we,
    input  logic [bpfa_pkg::COUNT_W-1:0]   i_cfg_count,
    input  logic                           i_rsp_ready,
    output logic                           o_rsp_valid,
    output logic [bpfa_pkg::STATUS_W-1:0]  o_rsp_status,
    output logic [bpfa_pkg::PAGE_W-1:0]    o_rsp_idx,
    output logic [bpfa_pkg::COUNT_W-1:0]   o_rsp_count
);
    import bpfa_pkg::*;

    // Bitmap storage: 1 = free
    logic [WORD_W-1:0] mem [MAP_WORDS];

    // Limits derived from page_count at write time
    logic [COUNT_W-1:0] r_lim;
    logic [PTR_W-1:0]   r_nwords;
    logic [PTR_W-1:0]   r_tail_word;
    logic [BIT_W-1:0]   r_tail;

    logic [COUNT_W-1:0] r_free_total;
    logic [WORD_AW-1:0] r_clr;

    logic               r_op;
    logic [PAGE_W-1:0]  r_idx;
    logic [PTR_W-1:0]   r_ptr;
    logic               r_rvalid;
    logic [WORD_AW-1:0] r_raddr;
    logic [WORD_W-1:0]  r_rdata;

    logic [WORD_AW-1:0] r_wr_addr;
    logic [WORD_W-1:0]  r_wr_data;
    t_status            r_status;
    logic [PAGE_W-1:0]  r_grant;

    logic               r_out_valid;
    t_status            r_out_status;
    logic [PAGE_W-1:0]  r_out_idx;
    logic [COUNT_W-1:0] r_out_count;

    logic [31:0]        cfg_lim32;
    logic [31:0]        cfg_nw32;
    logic [31:0]        cfg_tw32;
    logic [31:0]        in_word32;
    logic [31:0]        idx_word32;
    logic [31:0]        grant32;
    logic [WORD_AW-1:0] in_word;
    logic [WORD_AW-1:0] idx_word;
    logic [WORD_AW-1:0] rd_addr;
    logic               issue;
    logic [WORD_W-1:0]  tail_mask;
    logic [WORD_W-1:0]  masked;
    logic [WORD_W-1:0]  low_bit;
    logic [BIT_W-1:0]   low_pos;
    logic [WORD_W-1:0]  free_bit;
    logic               mem_we;
    logic [WORD_AW-1:0] mem_wa;
    logic [WORD_W-1:0]  mem_wd;

    // ---- limits -------------------------------------------------------------
    assign cfg_lim32 = (32'(i_cfg_count) > 32'(NUM_PAGES)) ? 32'(NUM_PAGES)
                                                             : 32'(i_cfg_count);
    assign cfg_nw32  = (cfg_lim32 + 32'(WORD_W - 1)) >> BIT_W;
    assign cfg_tw32  = cfg_lim32 >> BIT_W;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim       <= COUNT_W'(LIM_RST);
            r_nwords    <= PTR_W'(NW_RST);
            r_tail_word <= PTR_W'(TW_RST);
            r_tail      <= BIT_W'(TAIL_RST);
        end else if (i_cfg_we) begin
            r_lim       <= cfg_lim32[COUNT_W-1:0];
            r_nwords    <= cfg_nw32[PTR_W-1:0];
            r_tail_word <= cfg_tw32[PTR_W-1:0];
            r_tail      <= cfg_lim32[BIT_W-1:0];
        end
    end

    // ---- word addressing ----------------------------------------------------
    assign in_word32  = 32'(i_req_idx) >> BIT_W;
    assign idx_word32 = 32'(r_idx) >> BIT_W;
    assign in_word    = in_word32[WORD_AW-1:0];
    assign idx_word   = idx_word32[WORD_AW-1:0];

    assign issue   = i_cmd.scan && (r_ptr < r_nwords);
    assign rd_addr = i_cmd.scan ? r_ptr[WORD_AW-1:0] : in_word;

    // ---- scan: mask tail of last word, isolate lowest free bit --------------
    always_comb begin
        for (int i = 0; i < WORD_W; i++) begin
            tail_mask[i] = (r_tail == '0) || ({1'b0, r_raddr} != r_tail_word) ||
                           (BIT_W'(i) < r_tail);
        end
    end

    assign masked  = r_rdata & tail_mask;
    assign low_bit = masked & (~masked + WORD_W'(1));

    always_comb begin
        low_pos = '0;
        for (int b = 0; b < BIT_W; b++) begin
            for (int i = 0; i < WORD_W; i++) begin
                if (((i >> b) & 1) == 1) begin
                    low_pos[b] = low_pos[b] | low_bit[i];
                end
            end
        end
    end

    assign grant32  = 32'({r_raddr, low_pos});
    assign free_bit = WORD_W'(1) << r_idx[BIT_W-1:0];

    // ---- memory -------------------------------------------------------------
    assign mem_we = i_cmd.clr || i_cmd.wr;
    assign mem_wa = i_cmd.clr ? r_clr : r_wr_addr;
    assign mem_wd = i_cmd.clr ? '0 : r_wr_data;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rdata <= mem[rd_addr];
    end

    // ---- request state ------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr        <= '0;
            r_free_total <= '0;
            r_rvalid     <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_clr <= r_clr + WORD_AW'(1);
            end
            if (i_cmd.accept) begin
                r_rvalid <= 1'b0;
            end else if (i_cmd.scan) begin
                r_rvalid <= issue;
            end
            if (i_cmd.wr) begin
                if (r_op == OP_ALLOC) begin
                    r_free_total <= r_free_total - COUNT_W'(1);
                end else begin
                    r_free_total <= r_free_total + COUNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op     <= i_req_op;
            r_idx    <= i_req_idx;
            r_ptr    <= '0;
            r_grant  <= '0;
            r_status <= o_sts.range_err ? ST_RANGE : ST_OK;
        end
        if (i_cmd.scan) begin
            r_ptr   <= r_ptr + PTR_W'(1);
            r_raddr <= r_ptr[WORD_AW-1:0];
            if (o_sts.hit) begin
                r_wr_addr <= r_raddr;
                r_wr_data <= r_rdata & ~low_bit;
                r_grant   <= grant32[PAGE_W-1:0];
            end else if (o_sts.miss) begin
                r_status <= ST_OOM;
            end
        end
        if (i_cmd.free_chk) begin
            r_wr_addr <= idx_word;
            r_wr_data <= r_rdata | free_bit;
            if (o_sts.already) begin
                r_status <= ST_ALREADY;
            end
        end
    end

    // ---- output register ----------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= r_status;
            r_out_idx    <= r_grant;
            r_out_count  <= r_free_total;
        end
    end

    assign o_rsp_valid  = r_out_valid;
    assign o_rsp_status = r_out_status;
    assign o_rsp_idx    = r_out_idx;
    assign o_rsp_count  = r_out_count;

    // ---- status -------------------------------------------------------------
    assign o_sts.clr_done  = (r_clr == WORD_AW'(MAP_WORDS - 1));
    assign o_sts.req_alloc = (i_req_op == OP_ALLOC);
    assign o_sts.range_err = (i_req_op == OP_FREE) && (COUNT_W'(i_req_idx) >= r_lim);
    assign o_sts.hit       = r_rvalid && (masked != '0);
    assign o_sts.miss      = !r_rvalid && !issue;
    assign o_sts.already   = ((r_rdata & free_bit) != '0);
    assign o_sts.out_free  = !r_out_valid || i_rsp_ready;

endmodule

// ===== hdl/bitmap_page_frame_allocator_core.sv =====
// Bitmap first-fit page frame allocator.
//
// Channels: i_req takes one word per request (op: allocate or free, page_index
// for a free); o_rsp returns exactly one word per request (status, alloc_index,
// free_count after the request); i_cfg writes page_count and is always ready.
// Write page_count only while no request is outstanding.
//
// Reset: the bitmap is swept to all-used, one 64-bit word per cycle, so the
// block holds i_req.ready low until all 1024 (NUM_PAGES/64) words are swept.
// The free count starts at zero; software fills the map by issuing frees.
//
// One request at a time. A free: word read at accept, test bit, write back,
// load into the result register; a page already free skips the write back,
// one out of range goes straight to the load. An allocate scans words from
// 0 up to the first free page, a miss all nwords = ceil(min(page_count,
// NUM_PAGES)/64) <= 1024 of them. Accept resumes the cycle after load.
//
// A finished result sits in the output register; the next request is accepted
// while it waits. If the receiver is still stalled when the next result is
// ready, the block holds in its done state until o_rsp drains.
module bitmap_page_frame_allocator_core (
    input  logic i_clk,
    input  logic i_rst_n,
    bpfa_req_if.sink   i_req,
    bpfa_rsp_if.source o_rsp,
    bpfa_cfg_if.sink   i_cfg
);
    import bpfa_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // Register write never stalls
    assign i_cfg.ready = 1'b1;

    bpfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    bpfa_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .i_req_op     (i_req.op),
        .i_req_idx    (i_req.page_index),
        .i_cfg_we     (i_cfg.valid),
        .i_cfg_count  (i_cfg.page_count),
        .i_rsp_ready  (o_rsp.ready),
        .o_rsp_valid  (o_rsp.valid),
        .o_rsp_status (o_rsp.status),
        .o_rsp_idx    (o_rsp.alloc_index),
        .o_rsp_count  (o_rsp.free_count)
    );

endmodule

// ===== verif/bpfa_alloc_checker.sv =====
module bpfa_alloc_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    bpfa_req_if  i_req,
    bpfa_rsp_if  i_rsp,
    bpfa_cfg_if  i_cfg,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import bpfa_pkg::*;

    typedef struct {
        t_status            status;
        logic [PAGE_W-1:0]  alloc_index;
        logic [COUNT_W-1:0] free_count;
    } t_reply;

    // Shadow of the allocator: 1 = free
    logic [WORD_W-1:0]  page_map [MAP_WORDS];
    logic [COUNT_W-1:0] free_pages;
    logic [COUNT_W-1:0] page_count;
    t_reply             due_replies [$];
    int                 fails = 0;
    int                 outstanding = 0;

    assign o_fail_count = fails;
    assign o_pending    = outstanding;

    // Applies one request to the shadow map and returns the reply it owes.
    function automatic t_reply serve_request(t_op op, logic [PAGE_W-1:0] idx);
        t_reply            r;
        int                lim;
        int                nwords;
        int                rem;
        int                bit_pos;
        logic [WORD_W-1:0] w;
        r.status      = ST_OK;
        r.alloc_index = '0;
        lim = (page_count > NUM_PAGES) ? NUM_PAGES : int'(page_count);
        if (op == OP_ALLOC) begin
            r.status = ST_OOM;
            nwords   = (lim + WORD_W - 1) / WORD_W;
            for (int k = 0; k < nwords && r.status == ST_OOM; k++) begin
                w   = page_map[k];
                rem = lim - k * WORD_W;
                if (rem < WORD_W)
                    w &= (WORD_W'(1) << rem) - WORD_W'(1);
                if (w != '0) begin
                    bit_pos = 0;
                    for (int b = WORD_W - 1; b >= 0; b--)
                        if (w[b]) bit_pos = b;
                    page_map[k][bit_pos] = 1'b0;
                    free_pages    = free_pages - COUNT_W'(1);
                    r.alloc_index = PAGE_W'(k * WORD_W + bit_pos);
                    r.status      = ST_OK;
                end
            end
        end else if (int'(idx) >= lim) begin
            r.status = ST_RANGE;
        end else if (page_map[int'(idx) / WORD_W][int'(idx) % WORD_W]) begin
            r.status = ST_ALREADY;
        end else begin
            page_map[int'(idx) / WORD_W][int'(idx) % WORD_W] = 1'b1;
            free_pages = free_pages + COUNT_W'(1);
        end
        r.free_count = free_pages;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            foreach (page_map[k]) page_map[k] = '0;
            free_pages = '0;
            page_count = COUNT_W'(CNT_RST);
            due_replies.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready)
                page_count = i_cfg.page_count;
            // Drain before filling: a word leaving now belongs to an older request.
            if (i_rsp.valid && i_rsp.ready) begin
                if (due_replies.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: reply with none outstanding: st %0d idx %0d cnt %0d",
                                 $realtime, i_rsp.status, i_rsp.alloc_index,
                                 i_rsp.free_count);
                end else begin
                    want = due_replies.pop_front();
                    if (i_rsp.status !== want.status
                            || i_rsp.alloc_index !== want.alloc_index
                            || i_rsp.free_count !== want.free_count) begin
                        fails++;
                        if (fails <= 10)
                            $display("%0t: mismatch st %0d/%0d idx %0d/%0d cnt %0d/%0d (exp/act)",
                                     $realtime, want.status, i_rsp.status,
                                     want.alloc_index, i_rsp.alloc_index,
                                     want.free_count, i_rsp.free_count);
                    end
                end
            end
            if (i_req.valid && i_req.ready)
                due_replies.push_back(serve_request(t_op'(i_req.op), i_req.page_index));
        end
        outstanding = due_replies.size();
    end

endmodule

// ===== verif/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bpfa_pkg::*;

    logic clk;
    logic rst_n;

    bpfa_req_if req_ch ();
    bpfa_rsp_if rsp_ch ();
    bpfa_cfg_if cfg_ch ();

    int fail_count;
    int pending;

    // Stimulus bookkeeping
    bit                req_up    = 1'b0;  // request valid currently driven high
    bit                no_gaps   = 1'b0;  // sender runs back to back in this phase
    bit                hold_ask  = 1'b0;  // asks the receiver for its long stall
    int                words_sent = 0;
    logic [PAGE_W-1:0] freed_lately [$];  // recent free targets, to hit double frees

    int unsigned corner_counts [5] = '{0, 1, 63, 64, 65};
    int unsigned wide_counts   [3] = '{65535, 65536, 131071};

    bitmap_page_frame_allocator_core u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    // Watches all three channels, predicts every reply and compares.
    bpfa_alloc_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop. The slowest legal run is well under 20 ms: every
    // allocate may walk all 1024 map words, plus stalls and gaps.
    initial begin
        #100ms;
        $display("** bitmap_page_frame_allocator_core: FAILED **");
        $finish;
    end

    // Receiver: random ready pattern. Mostly short stalls, some long ones,
    // some long stretches of steady ready. One long hold, started as
    // soon as it is asked for, so the block parks a finished reply, takes the
    // next word (even a full-map walk) and then has to stall its input.
    initial begin
        int unsigned run;
        int unsigned roll;
        bit          level;
        bit          hold_done;
        hold_done = 1'b0;
        rsp_ch.ready <= 1'b0;
        forever begin
            roll = $urandom_range(99);
            if (hold_ask && !hold_done) begin
                hold_done = 1'b1;
                level     = 1'b0;
                run       = 3000;
            end else if (roll < 10) begin
                level = 1'b1;
                run   = $urandom_range(50, 200);
            end else if (roll < 60) begin
                level = 1'b1;
                run   = $urandom_range(1, 8);
            end else if (roll < 93) begin
                level = 1'b0;
                run   = $urandom_range(1, 3);
            end else begin
                level = 1'b0;
                run   = $urandom_range(15, 60);
            end
            repeat (run) begin
                @(posedge clk);
                if (hold_ask && !hold_done)
                    break;
                rsp_ch.ready <= level;
            end
        end
    end

    // Lower request valid, but only if it is up: keeps to one assignment per step.
    task automatic drop_req();
        if (req_up) begin
            req_ch.valid <= 1'b0;
            req_up = 1'b0;
        end
    endtask

    // Offers one request word and returns at the edge that accepts it.
    task automatic send_req(input t_op op, input logic [PAGE_W-1:0] idx);
        req_ch.valid      <= 1'b1;
        req_ch.op         <= op;
        req_ch.page_index <= idx;
        req_up = 1'b1;
        do @(posedge clk); while (!req_ch.ready);
        words_sent++;
    endtask

    // Gap after a word: none, short, or now and then long.
    task automatic pause_sender();
        int unsigned roll;
        int unsigned n;
        roll = $urandom_range(99);
        if (no_gaps || roll < 55)
            n = 0;
        else if (roll < 85)
            n = $urandom_range(1, 3);
        else if (roll < 97)
            n = $urandom_range(4, 12);
        else
            n = $urandom_range(20, 60);
        if (n > 0) begin
            drop_req();
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic issue(input t_op op, input logic [PAGE_W-1:0] idx);
        send_req(op, idx);
        pause_sender();
    endtask

    // page_count may only change with nothing in flight. Every request owes a
    // reply, so an empty prediction queue means nothing is in flight.
    task automatic set_page_count(input logic [COUNT_W-1:0] value);
        drop_req();
        do @(posedge clk); while (pending != 0);
        repeat (8) @(posedge clk);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.page_count <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // Small maps most often (fast scans), then corners, mid-size, full-size and any up to 131071.
    function automatic logic [COUNT_W-1:0] pick_page_count();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 45)
            return COUNT_W'($urandom_range(1, 300));
        if (roll < 60)
            return COUNT_W'(corner_counts[$urandom_range(4)]);
        if (roll < 72)
            return COUNT_W'($urandom_range(301, 4096));
        if (roll < 84)
            return COUNT_W'(wide_counts[$urandom_range(2)]);
        return COUNT_W'($urandom_range(0, 131071));
    endfunction

    // One random request for a map of lim managed pages. Allocates carry
    // random index bits, which the block must ignore.
    task automatic random_item(input int unsigned lim);
        int unsigned       roll;
        logic [PAGE_W-1:0] idx;
        roll = $urandom_range(99);
        if (roll < 45) begin
            issue(OP_ALLOC, PAGE_W'($urandom));
        end else if (roll < 80 && lim > 0) begin
            idx = PAGE_W'($urandom_range(lim - 1));
            freed_lately.push_back(idx);
            if (freed_lately.size() > 16)
                void'(freed_lately.pop_front());
            issue(OP_FREE, idx);
        end else if (roll < 92 && freed_lately.size() > 0) begin
            issue(OP_FREE, freed_lately[$urandom_range(freed_lately.size() - 1)]);
        end else begin
            issue(OP_FREE, PAGE_W'($urandom));
        end
    endtask

    initial begin
        int unsigned       phase_no;
        int unsigned       n_words;
        int unsigned       lim;
        logic [COUNT_W-1:0] cnt;

        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.op         <= OP_ALLOC;
        req_ch.page_index <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.page_count <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, reset page_count (all 65536 pages managed).
        // The block sweeps the map first; send_req just waits on ready.
        issue(OP_ALLOC, '0);              // empty map: out of memory, full walk
        issue(OP_FREE, 16'd0);
        issue(OP_FREE, 16'd0);            // double free
        issue(OP_FREE, 16'd63);           // last bit of word 0
        issue(OP_FREE, 16'd64);           // first bit of word 1
        issue(OP_FREE, 16'hFFFF);         // top page
        issue(OP_ALLOC, 16'hFFFF);        // -> 0, index bits ignored
        issue(OP_ALLOC, '0);              // -> 63
        issue(OP_ALLOC, '0);              // -> 64
        issue(OP_ALLOC, '0);              // -> 65535, walks to the last word
        issue(OP_ALLOC, '0);              // out of memory

        // No managed pages at all
        set_page_count('0);
        issue(OP_ALLOC, '0);
        issue(OP_FREE, 16'd0);
        issue(OP_FREE, 16'hFFFF);

        // Partial last word, range edge
        set_page_count(COUNT_W'(100));
        issue(OP_FREE, 16'd99);
        issue(OP_FREE, 16'd100);
        issue(OP_FREE, 16'd50);

        // Count lowered below set bits: those pages stay counted, not granted while out of range
        set_page_count(COUNT_W'(10));
        issue(OP_ALLOC, '0);
        issue(OP_FREE, 16'd50);

        // Count above capacity clips to the full map
        set_page_count(COUNT_W'(131071));
        issue(OP_FREE, 16'hFFFF);
        issue(OP_ALLOC, '0);              // -> 50
        issue(OP_ALLOC, '0);              // -> 99
        issue(OP_ALLOC, '0);              // -> 65535

        // Single managed page
        set_page_count(COUNT_W'(1));
        issue(OP_FREE, 16'd0);
        issue(OP_ALLOC, '0);

        // Random phases: new page_count each, then a burst of requests.
        phase_no = 0;
        while (words_sent < 555) begin
            phase_no++;
            cnt = pick_page_count();
            set_page_count(cnt);
            lim     = (cnt > NUM_PAGES) ? NUM_PAGES : cnt;
            no_gaps = ($urandom_range(3) == 0) || (phase_no == 2);
            if (phase_no == 2)
                hold_ask = 1'b1;          // long receiver stall while we keep sending
            n_words = $urandom_range(20, 60);
            repeat (n_words) random_item(lim);
        end

        // Drain, then watch for any stray reply.
        drop_req();
        do @(posedge clk); while (pending != 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("** bitmap_page_frame_allocator_core: PASSED **");
        else
            $display("** bitmap_page_frame_allocator_core: FAILED **");
        $finish;
    end

endmodule

// ===== bitmap_page_frame_allocator_core.f =====
hdl/bpfa_pkg.sv
hdl/bpfa_req_if.sv
hdl/bpfa_rsp_if.sv
hdl/bpfa_cfg_if.sv
hdl/bpfa_ctrl.sv
hdl/bpfa_dpath.sv
hdl/bitmap_page_frame_allocator_core.sv
verif/bpfa_alloc_checker.sv
verif/tb.sv
